>>> hw/rtl/press_qualifier_with_rearm_macros.svh
// assertion macros for the press qualifier checker
// expects a clock named clk and a synchronous reset named rst in scope
`ifndef PRESS_QUALIFIER_WITH_REARM_MACROS_SVH
`define PRESS_QUALIFIER_WITH_REARM_MACROS_SVH

// same-cycle implication, ignored while in reset
`define PQR_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pqr check failed");

// next-cycle implication, ignored while in reset
`define PQR_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pqr check failed");

// next-cycle implication that also covers reset itself
`define PQR_ASSERT_NXT_ALL(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("pqr check failed");

`endif

>>> hw/rtl/pqr_pkg.sv
// shared types, constants and helpers for the press qualifier
// no dependencies
package pqr_pkg;

  // configuration port geometry
  localparam int APB_ADDR_W = 4;
  localparam int APB_DATA_W = 32;

  // default timestamp width inside the block
  localparam int TIME_BITS_DEFAULT = 32;

  // register reset values
  localparam logic        RST_ACTIVE_LOW    = 1'b1;
  localparam logic [15:0] RST_REARM_WINDOW  = 16'd1000;
  localparam logic [15:0] RST_DEBOUNCE_TIME = 16'd50;
  localparam logic [15:0] RST_MIN_ON_TIME   = 16'd200;

  // request kinds
  localparam logic REQ_SAMPLE = 1'b0;
  localparam logic REQ_READ   = 1'b1;

  // reported mode codes
  localparam logic [2:0] MODE_CODE_WAIT     = 3'd0;
  localparam logic [2:0] MODE_CODE_ARMED    = 3'd1;
  localparam logic [2:0] MODE_CODE_DEBOUNCE = 3'd2;
  localparam logic [2:0] MODE_CODE_CONFIRM  = 3'd3;
  localparam logic [2:0] MODE_CODE_HELD     = 3'd4;

  // register word index
  typedef enum logic [1:0] {
    REG_ACTIVE_LOW    = 2'd0,
    REG_REARM_WINDOW  = 2'd1,
    REG_DEBOUNCE_TIME = 2'd2,
    REG_MIN_ON_TIME   = 2'd3
  } reg_idx_t;

  // qualifier modes, one-hot
  typedef enum logic [4:0] {
    MODE_WAIT     = 5'b00001,
    MODE_ARMED    = 5'b00010,
    MODE_DEBOUNCE = 5'b00100,
    MODE_CONFIRM  = 5'b01000,
    MODE_HELD     = 5'b10000
  } mode_t;

  // settings handed from the register block to the qualifier
  typedef struct packed {
    logic        active_low;
    logic [15:0] rearm_window;
    logic [15:0] debounce_time;
    logic [15:0] min_on_time;
  } cfg_t;

  // one result item
  typedef struct packed {
    logic       pressed_level;
    logic       event_fired;
    logic [2:0] mode_code;
  } result_t;

  // external code of a mode
  function automatic logic [2:0] mode_to_code(input mode_t m);
    logic [2:0] code;
    unique case (m)
      MODE_ARMED:    code = MODE_CODE_ARMED;
      MODE_DEBOUNCE: code = MODE_CODE_DEBOUNCE;
      MODE_CONFIRM:  code = MODE_CODE_CONFIRM;
      MODE_HELD:     code = MODE_CODE_HELD;
      default:       code = MODE_CODE_WAIT;
    endcase
    return code;
  endfunction

endpackage

>>> hw/rtl/pqr_cfg.sv
// register block for the press qualifier, read and written over the apb port
// depends on pqr_pkg
module pqr_cfg (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [pqr_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [pqr_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [pqr_pkg::APB_DATA_W-1:0]  prdata,
  output logic                            pready,
  output pqr_pkg::cfg_t                   cfg
);
  import pqr_pkg::*;

  reg_idx_t idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[3:2]);
  assign wr_en  = psel && penable && pwrite;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.active_low    <= RST_ACTIVE_LOW;
      cfg.rearm_window  <= RST_REARM_WINDOW;
      cfg.debounce_time <= RST_DEBOUNCE_TIME;
      cfg.min_on_time   <= RST_MIN_ON_TIME;
    end else if (wr_en) begin
      unique case (idx)
        REG_ACTIVE_LOW:    cfg.active_low    <= pwdata[0];
        REG_REARM_WINDOW:  cfg.rearm_window  <= pwdata[15:0];
        REG_DEBOUNCE_TIME: cfg.debounce_time <= pwdata[15:0];
        REG_MIN_ON_TIME:   cfg.min_on_time   <= pwdata[15:0];
      endcase
    end
  end

  // read mux
  always_comb begin
    prdata = '0;
    unique case (idx)
      REG_ACTIVE_LOW:    prdata[0]    = cfg.active_low;
      REG_REARM_WINDOW:  prdata[15:0] = cfg.rearm_window;
      REG_DEBOUNCE_TIME: prdata[15:0] = cfg.debounce_time;
      REG_MIN_ON_TIME:   prdata[15:0] = cfg.min_on_time;
    endcase
  end

endmodule

>>> hw/rtl/pqr_fsm.sv
// mode machine, time mark and event latch of the press qualifier
// depends on pqr_pkg
module pqr_fsm #(
  parameter int TIME_BITS = pqr_pkg::TIME_BITS_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step,
  input  logic                 req_type,
  input  logic                 pin_level,
  input  logic [TIME_BITS-1:0] now,
  input  pqr_pkg::cfg_t        cfg,
  output pqr_pkg::result_t     res
);
  import pqr_pkg::*;

  mode_t                mode;
  mode_t                mode_next;
  logic [TIME_BITS-1:0] time_mark;
  logic [TIME_BITS-1:0] time_mark_next;
  logic                 pressed;
  logic                 pressed_next;
  logic                 event_latch;
  logic                 event_latch_next;
  logic                 fired;
  logic                 act;
  logic [TIME_BITS-1:0] elapsed;
  logic                 rearm_done;
  logic                 debounce_done;
  logic                 min_on_done;

  // contact activity and wrapping elapsed time
  assign act           = pin_level ^ cfg.active_low;
  assign elapsed       = now - time_mark;
  assign rearm_done    = elapsed >= TIME_BITS'(cfg.rearm_window);
  assign debounce_done = elapsed >= TIME_BITS'(cfg.debounce_time);
  assign min_on_done   = elapsed >= TIME_BITS'(cfg.min_on_time);

  // next state for the item in flight
  always_comb begin
    mode_next        = mode;
    time_mark_next   = time_mark;
    pressed_next     = pressed;
    event_latch_next = event_latch;
    fired            = 1'b0;
    if (req_type == REQ_READ) begin
      fired            = event_latch;
      event_latch_next = 1'b0;
    end else begin
      unique case (mode)
        MODE_ARMED: begin
          if (act) begin
            time_mark_next = now;
            mode_next      = MODE_DEBOUNCE;
          end
        end
        MODE_DEBOUNCE: begin
          if (!act) begin
            mode_next = MODE_ARMED;
          end else if (debounce_done) begin
            pressed_next = 1'b1;
            mode_next    = MODE_CONFIRM;
          end
        end
        MODE_CONFIRM: begin
          if (!act) begin
            pressed_next   = 1'b0;
            time_mark_next = now;
            mode_next      = MODE_WAIT;
          end else if (min_on_done) begin
            event_latch_next = 1'b1;
            mode_next        = MODE_HELD;
          end
        end
        MODE_HELD: begin
          if (!act) begin
            pressed_next   = 1'b0;
            time_mark_next = now;
            mode_next      = MODE_WAIT;
          end
        end
        default: begin
          // wait for release, also the fallback for stray codes
          mode_next = MODE_WAIT;
          if (act) begin
            time_mark_next = now;
          end else if (rearm_done) begin
            mode_next = MODE_ARMED;
          end
        end
      endcase
    end
  end

  // state update when an item leaves the input stage
  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= MODE_WAIT;
      time_mark   <= '0;
      pressed     <= 1'b0;
      event_latch <= 1'b0;
    end else if (step) begin
      mode        <= mode_next;
      time_mark   <= time_mark_next;
      pressed     <= pressed_next;
      event_latch <= event_latch_next;
    end
  end

  assign res.pressed_level = pressed_next;
  assign res.event_fired   = fired;
  assign res.mode_code     = mode_to_code(mode_next);

endmodule

>>> hw/rtl/press_qualifier_with_rearm.sv
// Press qualifier with rearm window: turns timestamped contact samples into
// a debounced pressed level and a latched press event.
//
// Input channel (in_valid / in_stall): one transfer per item. req_type 0 is
// a sample (pin_level, now_ms), req_type 1 reads and clears the event.
// Output channel (out_valid / out_stall): exactly one result per item,
// pressed_level, event_fired and mode_code, in item order.
// Settings sit behind the apb port at byte addresses 0, 4, 8, 12:
// active_low, rearm_window, debounce_time, min_on_time.
//
// Pipeline: an item taken into the input register passes the mode update and
// has its result in the output register. Throughput: one item per cycle while
// the receiver does not stall, set by the mode update between the input
// register and the output register.
// Reset clears both stages, the mode (back to wait for release), the time
// mark, the pressed flag and the event latch, and reloads register defaults.
// While the receiver stalls, the result holds; one more item may wait in
// the input register, then in_stall rises until the result is taken.
// depends on pqr_pkg, pqr_cfg, pqr_fsm
module press_qualifier_with_rearm #(
  parameter int TIME_BITS = pqr_pkg::TIME_BITS_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [pqr_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [pqr_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [pqr_pkg::APB_DATA_W-1:0]  prdata,
  output logic                            pready,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            req_type,
  input  logic                            pin_level,
  input  logic [31:0]                     now_ms,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            pressed_level,
  output logic                            event_fired,
  output logic [2:0]                      mode_code
);
  import pqr_pkg::*;

  cfg_t                 cfg;
  result_t              res;
  logic                 s1_valid;
  logic                 s1_req;
  logic                 s1_pin;
  logic [TIME_BITS-1:0] s1_now;
  logic                 advance;
  logic                 step;
  logic                 in_take;

  // flow control between the two stages
  assign advance  = !out_valid || !out_stall;
  assign step     = s1_valid && advance;
  assign in_stall = s1_valid && !advance;
  assign in_take  = in_valid && !in_stall;

  pqr_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_req <= req_type;
      s1_pin <= pin_level;
      s1_now <= TIME_BITS'(now_ms);
    end
  end

  pqr_fsm #(
    .TIME_BITS (TIME_BITS)
  ) u_fsm (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .req_type  (s1_req),
    .pin_level (s1_pin),
    .now       (s1_now),
    .cfg       (cfg),
    .res       (res)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      pressed_level <= res.pressed_level;
      event_fired   <= res.event_fired;
      mode_code     <= res.mode_code;
    end
  end

endmodule

>>> hw/rtl/pqr_checker.sv
// port-level checks for the press qualifier and their bind to the top level
// depends on pqr_pkg and press_qualifier_with_rearm_macros.svh
`include "press_qualifier_with_rearm_macros.svh"

module pqr_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic       pressed_level,
  input logic       event_fired,
  input logic [2:0] mode_code
);
  import pqr_pkg::*;

  // no result shows right after reset
  `PQR_ASSERT_NXT_ALL(a_rst_empty, rst, !out_valid)

  // with the output register empty the input side never stalls
  `PQR_ASSERT_IMP(a_no_stall_empty, !out_valid, !in_stall)

  // pressed level follows the debounced modes
  `PQR_ASSERT_IMP(a_pressed_mode, out_valid,
    pressed_level == (mode_code == MODE_CODE_CONFIRM || mode_code == MODE_CODE_HELD))

  // a stalled result holds
  `PQR_ASSERT_NXT(a_hold, out_valid && out_stall,
    out_valid && $stable(mode_code) && $stable(event_fired) && $stable(pressed_level))

endmodule

bind press_qualifier_with_rearm pqr_checker u_pqr_checker (
  .clk           (clk),
  .rst           (rst),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .pressed_level (pressed_level),
  .event_fired   (event_fired),
  .mode_code     (mode_code)
);

>>> tb/sv/tb_press_qualifier_with_rearm.sv
// self-checking testbench for press_qualifier_with_rearm
// depends on pqr_pkg and the press_qualifier_with_rearm rtl
`timescale 1ns / 100ps

module tb_press_qualifier_with_rearm;
  import pqr_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int ITEMS_PER_PHASE = 667;
  localparam int SQUEEZE_CYCLES = 80;
  localparam int MAX_REPORTS = 10;

  typedef enum logic {ROW_ITEM, ROW_WRITE} row_kind_t;

  typedef struct {
    row_kind_t   kind;
    logic        req;
    logic        pin;
    logic [31:0] now;
    reg_idx_t    idx;
    logic [31:0] wval;
    logic        typed;
    result_t     want;
  } row_t;

  logic clk;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic pready;
  logic in_valid;
  logic in_stall;
  logic req_type;
  logic pin_level;
  logic [31:0] now_ms;
  logic out_valid;
  logic out_stall;
  logic pressed_level;
  logic event_fired;
  logic [2:0] mode_code;

  press_qualifier_with_rearm uut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_stall(in_stall),
    .req_type(req_type), .pin_level(pin_level), .now_ms(now_ms),
    .out_valid(out_valid), .out_stall(out_stall),
    .pressed_level(pressed_level), .event_fired(event_fired), .mode_code(mode_code)
  );

  // settings as the block should hold them
  logic        set_active_low;
  logic [15:0] set_rearm;
  logic [15:0] set_debounce;
  logic [15:0] set_min_on;

  // qualifier state mirrored by the predictor
  logic [2:0]  qual_mode;
  logic [31:0] qual_mark;
  logic        qual_pressed;
  logic        qual_latch;

  result_t press_results_due[$];
  row_t    directed_rows[$];

  int errors;
  int progress;
  int n_items;
  int n_reads;
  int n_results;
  int n_events;
  int mode_seen [5];
  int send_idle_pct;
  int recv_idle_pct;
  logic squeeze_on;

  // random press generator state
  logic [31:0] gen_now;
  logic        gen_press;
  int          gen_left;
  int unsigned gen_span;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // expected result of one item, advancing the mirrored state
  function automatic result_t qualify_item(input logic req, input logic pin,
                                           input logic [31:0] now);
    result_t r;
    logic act;
    logic [31:0] since;
    r.event_fired = 1'b0;
    if (req == REQ_READ) begin
      r.event_fired = qual_latch;
      qual_latch = 1'b0;
    end else begin
      act = set_active_low ? (pin == 1'b0) : (pin == 1'b1);
      since = now - qual_mark;
      case (qual_mode)
        MODE_CODE_ARMED: begin
          if (act) begin
            qual_mark = now;
            qual_mode = MODE_CODE_DEBOUNCE;
          end
        end
        MODE_CODE_DEBOUNCE: begin
          if (!act) begin
            qual_mode = MODE_CODE_ARMED;
          end else if (since >= {16'h0, set_debounce}) begin
            qual_pressed = 1'b1;
            qual_mode = MODE_CODE_CONFIRM;
          end
        end
        MODE_CODE_CONFIRM: begin
          if (!act) begin
            qual_pressed = 1'b0;
            qual_mark = now;
            qual_mode = MODE_CODE_WAIT;
          end else if (since >= {16'h0, set_min_on}) begin
            qual_latch = 1'b1;
            qual_mode = MODE_CODE_HELD;
          end
        end
        MODE_CODE_HELD: begin
          if (!act) begin
            qual_pressed = 1'b0;
            qual_mark = now;
            qual_mode = MODE_CODE_WAIT;
          end
        end
        default: begin
          qual_mode = MODE_CODE_WAIT;
          if (act) begin
            qual_mark = now;
          end else if (since >= {16'h0, set_rearm}) begin
            qual_mode = MODE_CODE_ARMED;
          end
        end
      endcase
    end
    r.pressed_level = qual_pressed;
    r.mode_code = qual_mode;
    return r;
  endfunction

  // table row builders
  function automatic row_t item_row(input logic req, input logic pin, input logic [31:0] now);
    row_t r;
    r = '{ROW_ITEM, req, pin, now, REG_ACTIVE_LOW, 32'h0, 1'b0, '0};
    return r;
  endfunction

  function automatic row_t typed_row(input logic req, input logic pin, input logic [31:0] now,
                                     input result_t want);
    row_t r;
    r = '{ROW_ITEM, req, pin, now, REG_ACTIVE_LOW, 32'h0, 1'b1, want};
    return r;
  endfunction

  function automatic row_t write_row(input reg_idx_t idx, input logic [31:0] value);
    row_t r;
    r = '{ROW_WRITE, REQ_SAMPLE, 1'b0, 32'h0, idx, value, 1'b0, '0};
    return r;
  endfunction

  function automatic logic [15:0] pick_extreme();
    int unsigned roll;
    roll = $urandom_range(2);
    if (roll == 0) return 16'h0000;
    if (roll == 1) return 16'hFFFF;
    return 16'($urandom());
  endfunction

  // one register write over apb: setup then access
  task automatic write_setting(input reg_idx_t idx, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    progress++;
    case (idx)
      REG_ACTIVE_LOW:    set_active_low = value[0];
      REG_REARM_WINDOW:  set_rearm = value[15:0];
      REG_DEBOUNCE_TIME: set_debounce = value[15:0];
      REG_MIN_ON_TIME:   set_min_on = value[15:0];
      default: ;
    endcase
  endtask

  // offer one item until the transfer happens, then log its expectation
  task automatic offer_item(input logic req, input logic pin, input logic [31:0] now,
                            input logic typed, input result_t want);
    result_t pred;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    req_type <= req;
    pin_level <= pin;
    now_ms <= now;
    do @(posedge clk); while (in_stall !== 1'b0);
    pred = qualify_item(req, pin, now);
    press_results_due.push_back(typed ? want : pred);
    progress++;
    n_items++;
    if (req == REQ_READ) n_reads++;
  endtask

  // stop offering and let every outstanding result come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (press_results_due.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // next random item: mostly press sequences with bounce, some reads and noise
  task automatic next_press_item(output logic req, output logic pin, output logic [31:0] now);
    int unsigned roll;
    logic act;
    roll = $urandom_range(99);
    if (roll < 10) begin
      req = REQ_READ;
      pin = 1'($urandom());
      now = $urandom();
    end else if (roll < 15) begin
      req = REQ_SAMPLE;
      pin = 1'($urandom());
      now = $urandom();
    end else begin
      if (gen_left == 0) begin
        gen_press = !gen_press;
        gen_left = $urandom_range(1, 12);
      end
      gen_left--;
      gen_now += $urandom_range(0, gen_span);
      if (roll < 17) gen_now += $urandom();
      act = gen_press ^ ($urandom_range(99) < 8);
      req = REQ_SAMPLE;
      pin = set_active_low ? !act : act;
      now = gen_now;
    end
  endtask

  // output side: check each result transfer and drive stall
  initial begin
    result_t want;
    result_t got;
    int hold_left;
    logic squeezed;
    hold_left = 0;
    squeezed = 1'b0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid === 1'b1 && out_stall === 1'b0) begin
        got = '{pressed_level, event_fired, mode_code};
        n_results++;
        progress++;
        if (got.event_fired === 1'b1) n_events++;
        if (got.mode_code < 3'd5) mode_seen[got.mode_code]++;
        if (press_results_due.size() == 0) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("result %0d arrived with nothing outstanding", n_results);
        end else begin
          want = press_results_due.pop_front();
          if (got.pressed_level !== want.pressed_level ||
              got.event_fired !== want.event_fired ||
              got.mode_code !== want.mode_code) begin
            errors++;
            if (errors <= MAX_REPORTS)
              $display("result %0d: expected pressed=%0b fired=%0b mode=%0d, got %0b %0b %0d",
                       n_results, want.pressed_level, want.event_fired, want.mode_code,
                       got.pressed_level, got.event_fired, got.mode_code);
          end
        end
      end
      // one long hold-off so the block backs up into its input
      if (squeeze_on && !squeezed) begin
        hold_left = SQUEEZE_CYCLES;
        squeezed = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // watchdog on cycles without any transfer
  initial begin
    int stuck;
    int last_seen;
    stuck = 0;
    last_seen = 0;
    while (stuck < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (progress != last_seen) begin
        stuck = 0;
        last_seen = progress;
      end else begin
        stuck++;
      end
    end
    $display("no transfer for %0d cycles, %0d results outstanding",
             WATCHDOG_LIMIT, press_results_due.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // stimulus
  initial begin
    logic [31:0] vals [4];
    logic req;
    logic pin;
    logic [31:0] now;
    int unsigned widest;

    errors = 0;
    progress = 0;
    n_items = 0;
    n_reads = 0;
    n_results = 0;
    n_events = 0;
    foreach (mode_seen[m]) mode_seen[m] = 0;
    squeeze_on = 1'b0;
    send_idle_pct = 35;
    recv_idle_pct = 53;

    set_active_low = RST_ACTIVE_LOW;
    set_rearm = RST_REARM_WINDOW;
    set_debounce = RST_DEBOUNCE_TIME;
    set_min_on = RST_MIN_ON_TIME;
    qual_mode = MODE_CODE_WAIT;
    qual_mark = 32'h0;
    qual_pressed = 1'b0;
    qual_latch = 1'b0;

    rst <= 1'b1;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    in_valid <= 1'b0;
    req_type <= REQ_SAMPLE;
    pin_level <= 1'b0;
    now_ms <= 32'h0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    directed_rows = '{
      // reset settings: active low, 1000 / 50 / 200 ms
      typed_row(REQ_READ, 1'b0, 32'd0, '{1'b0, 1'b0, MODE_CODE_WAIT}),
      typed_row(REQ_SAMPLE, 1'b1, 32'd0, '{1'b0, 1'b0, MODE_CODE_WAIT}),
      item_row(REQ_SAMPLE, 1'b1, 32'd1000),
      item_row(REQ_SAMPLE, 1'b0, 32'd1005),
      item_row(REQ_SAMPLE, 1'b1, 32'd1010),
      item_row(REQ_SAMPLE, 1'b0, 32'd1020),
      item_row(REQ_SAMPLE, 1'b0, 32'd1070),
      item_row(REQ_SAMPLE, 1'b0, 32'd1220),
      item_row(REQ_READ, 1'b0, 32'd0),
      item_row(REQ_READ, 1'b0, 32'd0),
      item_row(REQ_SAMPLE, 1'b1, 32'd1300),
      // active high, all windows zero, timestamps wrapping
      write_row(REG_ACTIVE_LOW, 32'd0),
      write_row(REG_REARM_WINDOW, 32'd0),
      write_row(REG_DEBOUNCE_TIME, 32'd0),
      write_row(REG_MIN_ON_TIME, 32'd0),
      item_row(REQ_SAMPLE, 1'b0, 32'hFFFF_FFFF),
      item_row(REQ_SAMPLE, 1'b1, 32'hFFFF_FFF0),
      item_row(REQ_SAMPLE, 1'b1, 32'hFFFF_FFF0),
      item_row(REQ_SAMPLE, 1'b1, 32'h0000_0005),
      item_row(REQ_SAMPLE, 1'b0, 32'h0000_0007),
      item_row(REQ_READ, 1'b1, 32'hFFFF_FFFF),
      // widest rearm and debounce, min-on below debounce
      write_row(REG_ACTIVE_LOW, 32'd1),
      write_row(REG_REARM_WINDOW, 32'h0000_FFFF),
      write_row(REG_DEBOUNCE_TIME, 32'h0000_FFFF),
      write_row(REG_MIN_ON_TIME, 32'd0),
      item_row(REQ_SAMPLE, 1'b1, 32'h0000_0010),
      item_row(REQ_SAMPLE, 1'b1, 32'h0001_0006),
      item_row(REQ_SAMPLE, 1'b0, 32'h8000_0000),
      item_row(REQ_SAMPLE, 1'b0, 32'h8000_FFFE),
      item_row(REQ_SAMPLE, 1'b0, 32'h8000_FFFF),
      item_row(REQ_SAMPLE, 1'b0, 32'h8000_FFFF),
      item_row(REQ_SAMPLE, 1'b1, 32'h8001_0000),
      item_row(REQ_READ, 1'b0, 32'd0)
    };

    // directed table
    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_WRITE) begin
        wait_drained();
        write_setting(directed_rows[i].idx, directed_rows[i].wval);
      end else begin
        offer_item(directed_rows[i].req, directed_rows[i].pin, directed_rows[i].now,
                   directed_rows[i].typed, directed_rows[i].want);
      end
    end

    // random phases, each with fresh settings and its own idle pattern
    for (int phase = 0; phase < 3; phase++) begin
      wait_drained();
      case (phase)
        0: begin
          send_idle_pct = 35;
          recv_idle_pct = 53;
          vals[1] = $urandom_range(0, 400);
          vals[2] = $urandom_range(0, 100);
          vals[3] = $urandom_range(0, 300);
        end
        1: begin
          send_idle_pct = 53;
          recv_idle_pct = 35;
          vals[1] = {16'h0, pick_extreme()};
          vals[2] = {16'h0, pick_extreme()};
          vals[3] = {16'h0, pick_extreme()};
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
          vals[1] = $urandom_range(0, 2000);
          vals[2] = $urandom_range(0, 300);
          vals[3] = $urandom_range(0, 600);
        end
      endcase
      vals[0] = $urandom_range(0, 1);
      // upper data bits carry noise that the registers must drop
      for (int r = 0; r < 4; r++) begin
        now = $urandom();
        if (r == 0) vals[r] = {now[31:1], vals[r][0]};
        else vals[r] = {now[31:16], vals[r][15:0]};
        write_setting(reg_idx_t'(r), vals[r]);
        // bus goes idle between apb transfers
        @(posedge clk);
      end
      widest = {16'h0, set_rearm};
      if ({16'h0, set_debounce} > widest) widest = {16'h0, set_debounce};
      if ({16'h0, set_min_on} > widest) widest = {16'h0, set_min_on};
      gen_span = widest / 3 + 1;
      gen_now = $urandom();
      gen_press = 1'b1;
      gen_left = 0;
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        if (phase == 2 && k == 100) squeeze_on = 1'b1;
        next_press_item(req, pin, now);
        offer_item(req, pin, now, 1'b0, '0);
      end
    end

    wait_drained();
    $display("covered %0d items (%0d reads) over the directed table and three setting phases",
             n_items, n_reads);
    $display("%0d results, %0d press events, modes wait to held %0d/%0d/%0d/%0d/%0d",
             n_results, n_events, mode_seen[0], mode_seen[1], mode_seen[2], mode_seen[3],
             mode_seen[4]);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("%0d mismatches", errors);
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+hw/rtl
hw/rtl/pqr_pkg.sv
hw/rtl/pqr_cfg.sv
hw/rtl/pqr_fsm.sv
hw/rtl/press_qualifier_with_rearm.sv
hw/rtl/pqr_checker.sv
tb/sv/tb_press_qualifier_with_rearm.sv
